@@ sv/wpo_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the oscillator.
`timescale 1ns / 1ps

package wpo_pkg;

    localparam int PHASE_BITS        = 32;
    localparam int SAMPLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH  = 256;
    localparam int SINE_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam int MAX_BURST         = 64;
    localparam int COUNT_BITS        = $clog2(MAX_BURST + 1);

    localparam int SAMPLE_COUNT_BITS = 7;
    localparam int WAVE_SEL_BITS     = 2;
    localparam int STEP_BITS         = 32;

    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM_SELECT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP      = 2'd1;

    localparam logic [WAVE_SEL_BITS-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_SEL_BITS-1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [WAVE_SEL_BITS-1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [WAVE_SEL_BITS-1:0] WAVE_SAWTOOTH = 2'd3;

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RESET = 32'd39370534;

    // The phase accumulator lives in a small RAM; only one entry is used.
    localparam int PHASE_RAM_DEPTH     = 2;
    localparam int PHASE_RAM_ADDR_BITS = 1;
    localparam logic [PHASE_RAM_ADDR_BITS-1:0] PHASE_ENTRY = 1'b0;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Table generation, evaluated at elaboration only.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int ROUND_SHIFT = 30 - (SAMPLE_BITS - 1);
    localparam logic [63:0] SERIES_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

    typedef logic [SAMPLE_BITS-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        int                 k;
        int                 n;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
            term = x;
            sum  = $signed(x);
            // Taylor series of sin through x^15 in Q30 with truncation.
            for (n = 1; n <= 7; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / SERIES_DIV[n-1];
                if ((n % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 64'sd0;
            v = ($unsigned(sum) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            if (v > 64'(SAMPLE_MAX))
                v = 64'(SAMPLE_MAX);
            rom[k] = v[SAMPLE_BITS-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ sv/waveform_phase_oscillator_unit.sv @@
// Top level of the phase-accumulator oscillator: burst control, registers, output stage.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | to block  | in_valid / in_ready   | sample_count
//   out     | from block| out_valid / out_ready | sample_value, last_sample
//   cfg     | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A burst first accepts the request and issues the phase RAM read, then waits in the
// load state for the read data, then emits one sample per cycle when not stalled.
// The phase is read from its RAM once per burst and forwarded through a register
// while the burst runs; every sample writes the advanced phase back.
// Reset leaves the phase entry unwritten; a valid flag makes it read as zero.
// A stalled output holds the sample register and the burst pauses with it.
`timescale 1ns / 1ps

module waveform_phase_oscillator_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [wpo_pkg::SAMPLE_COUNT_BITS-1:0]  sample_count,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [wpo_pkg::SAMPLE_BITS-1:0] sample_value,
    output logic                                   last_sample,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [wpo_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [wpo_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam int PB = wpo_pkg::PHASE_BITS;
    localparam int SB = wpo_pkg::SAMPLE_BITS;
    localparam int CB = wpo_pkg::COUNT_BITS;

    logic [1:0]                       state_reg, state_next;
    logic [CB-1:0]                    remain_reg, remain_next;
    logic [PB-1:0]                    phase_reg, phase_next;
    logic                             phase_written_reg;
    logic [wpo_pkg::WAVE_SEL_BITS-1:0] wave_sel_reg;
    logic [wpo_pkg::STEP_BITS-1:0]    phase_step_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [SB-1:0]                    sample_reg;
    logic                             last_reg;

    logic [CB-1:0]                    burst_len;
    logic                             emit;
    logic [PB-1:0]                    phase_sum;
    logic [SB-1:0]                    wave_sample;
    logic                             ram_re;
    logic                             ram_we;
    logic [PB-1:0]                    ram_rdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign sample_value = $signed(sample_reg);
    assign last_sample  = last_reg;

    assign burst_len = (sample_count > wpo_pkg::SAMPLE_COUNT_BITS'(wpo_pkg::MAX_BURST))
                     ? CB'(wpo_pkg::MAX_BURST) : CB'(sample_count);
    assign emit      = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign phase_sum = phase_reg + PB'(phase_step_reg);

    wpo_ram #(
        .WIDTH (PB),
        .DEPTH (wpo_pkg::PHASE_RAM_DEPTH)
    ) u_phase_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpo_pkg::PHASE_ENTRY),
        .wdata (phase_sum),
        .re    (ram_re),
        .raddr (wpo_pkg::PHASE_ENTRY),
        .rdata (ram_rdata)
    );

    wpo_wave u_wave (
        .phase    (phase_reg),
        .wave_sel (wave_sel_reg),
        .sample   (wave_sample)
    );

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        phase_next  = phase_reg;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // An empty request is taken and produces nothing.
                if (in_valid && (burst_len != '0))
                begin
                    ram_re      = 1'b1;
                    remain_next = burst_len;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                phase_next = phase_written_reg ? ram_rdata : '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    ram_we      = 1'b1;
                    phase_next  = phase_sum;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CB'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            remain_reg        <= '0;
            out_valid_reg     <= 1'b0;
            phase_written_reg <= 1'b0;
            wave_sel_reg      <= wpo_pkg::WAVE_SINE;
            phase_step_reg    <= wpo_pkg::PHASE_STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
                phase_written_reg <= 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wpo_pkg::REG_WAVEFORM_SELECT:
                        wave_sel_reg <= cfg_data[wpo_pkg::WAVE_SEL_BITS-1:0];
                    wpo_pkg::REG_PHASE_STEP:
                        phase_step_reg <= cfg_data[wpo_pkg::STEP_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        if (emit)
        begin
            sample_reg <= wave_sample;
            last_reg   <= (remain_reg == CB'(1));
        end
    end

    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (remain_reg != '0))
        else $error("burst running with no samples left");

    a_load_to_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_RUN))
        else $error("phase load did not start the burst");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (remain_reg == CB'(1))) |=> (state_reg == ST_IDLE) && last_reg)
        else $error("final sample did not close the burst");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == $past(phase_sum)))
        else $error("phase did not advance by the step");

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("sample produced without output valid");

endmodule

@@ sv/wpo_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module wpo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/wpo_wave.sv @@
// Waveform shaper: maps a phase to a sine, square, triangle or sawtooth sample.
`timescale 1ns / 1ps

module wpo_wave (
    input  logic [wpo_pkg::PHASE_BITS-1:0]    phase,
    input  logic [wpo_pkg::WAVE_SEL_BITS-1:0] wave_sel,
    output logic [wpo_pkg::SAMPLE_BITS-1:0]   sample
);

    localparam int PB       = wpo_pkg::PHASE_BITS;
    localparam int SB       = wpo_pkg::SAMPLE_BITS;
    localparam int AB       = wpo_pkg::SINE_ADDR_BITS;
    localparam int SCALE_W  = ((PB > SB) ? PB : SB) + 1;
    localparam int SCALE_DN = (PB >= SB) ? (PB - SB) : 0;
    localparam int SCALE_UP = (PB >= SB) ? 0 : (SB - PB);

    logic [1:0]         quad;
    logic [AB-1:0]      idx;
    logic [AB-1:0]      rom_addr;
    logic               rom_top;
    logic [SB-1:0]      mag;
    logic [SB-1:0]      sine_val;
    logic [PB-1:0]      dbl;
    logic [PB:0]        tri_u;
    logic [SCALE_W-1:0] tri_w;
    logic [SB:0]        tri_s;
    logic [SB-1:0]      tri_val;
    logic [SCALE_W-1:0] saw_w;
    logic [SB-1:0]      saw_s;
    logic [SB-1:0]      saw_val;

    always_comb
    begin
        // Sine: the top two bits pick the quadrant, odd quadrants mirror the index.
        quad     = phase[PB-1 -: 2];
        idx      = phase[PB-3 -: AB];
        rom_top  = quad[0] && (idx == '0);
        rom_addr = quad[0] ? AB'(~idx + 1'b1) : idx;
        mag      = rom_top ? wpo_pkg::SINE_ROM[wpo_pkg::SINE_TABLE_DEPTH]
                           : wpo_pkg::SINE_ROM[rom_addr];
        sine_val = quad[1] ? SB'(~mag + 1'b1) : mag;

        // Triangle: |2*phase - turn|, which reaches a full turn at phase zero.
        dbl   = {phase[PB-2:0], 1'b0};
        tri_u = phase[PB-1] ? {1'b0, dbl} : ({1'b1, {PB{1'b0}}} - {1'b0, dbl});
        tri_w = (SCALE_W'(tri_u) >> SCALE_DN) << SCALE_UP;
        tri_s = tri_w[SB:0];
        tri_val = tri_s[SB] ? wpo_pkg::SAMPLE_MAX : {~tri_s[SB-1], tri_s[SB-2:0]};

        saw_w   = (SCALE_W'(phase) >> SCALE_DN) << SCALE_UP;
        saw_s   = saw_w[SB-1:0];
        saw_val = {~saw_s[SB-1], saw_s[SB-2:0]};

        unique case (wave_sel)
            wpo_pkg::WAVE_SINE:     sample = sine_val;
            wpo_pkg::WAVE_SQUARE:   sample = phase[PB-1] ? wpo_pkg::SAMPLE_MIN
                                                         : wpo_pkg::SAMPLE_MAX;
            wpo_pkg::WAVE_TRIANGLE: sample = tri_val;
            wpo_pkg::WAVE_SAWTOOTH: sample = saw_val;
            default:                sample = sine_val;
        endcase
    end

endmodule
